// File: hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest point search core.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;

    localparam int IDX_OUT_W   = 10;
    localparam int CNT_CFG_W   = 11;
    localparam int LIMIT_W     = 25;
    localparam int DIST_W      = 25;
    localparam int LIM2_W      = 2 * LIMIT_W;
    localparam int OUT_FIELDS_W = 1 + IDX_OUT_W + DIST_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_POINT_COUNT    = 1'b0;
    localparam logic REG_DISTANCE_LIMIT = 1'b1;

    typedef struct packed {
        logic start;
        logic wr;
        logic rd;
        logic sqrt_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic found;
        logic sqrt_done;
        logic out_free;
    } t_status;

endpackage

// File: hdl/nearest_point_search_core.sv
// ----------------------------------------------------------------------------
// nearest_point_search_core
// Brute-force 3D nearest point search over a table of fixed-point points.
// ----------------------------------------------------------------------------
// A write request gives no result. A query request scans
// min(point_count, MAX_POINTS) entries at one per cycle through the single
// table read port, waits for the distance pipeline to drain, and then runs
// the bit-serial square root only when a match is found. The next request
// is taken as soon as the result sits in the output register, even if it
// has not yet been collected.
module nearest_point_search_core #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // entry_index, coord_x, coord_y, coord_z
    input  logic [((10 + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // opcode
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // found, nearest_index, distance
    output logic [nps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nps_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [nps_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [nps_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int C     = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int XL    = nps_pkg::IDX_OUT_W;

    logic [nps_pkg::CNT_CFG_W-1:0] point_count;
    logic [nps_pkg::LIMIT_W-1:0]   distance_limit;
    nps_pkg::t_cmd                 cmd;
    nps_pkg::t_status              status;
    logic [IDX_W-1:0]              rd_addr;

    nps_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_point_count    (point_count),
        .o_distance_limit (distance_limit)
    );

    nps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_opcode      (s_axis_tuser),
        .i_point_count (point_count),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr),
        .o_s_tready    (s_axis_tready)
    );

    nps_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .i_entry_index    (s_axis_tdata[XL-1:0]),
        .i_coord_x        (s_axis_tdata[XL +: C]),
        .i_coord_y        (s_axis_tdata[XL + C +: C]),
        .i_coord_z        (s_axis_tdata[XL + 2 * C +: C]),
        .i_distance_limit (distance_limit),
        .i_m_tready       (m_axis_tready),
        .o_status         (status),
        .o_m_tvalid       (m_axis_tvalid),
        .o_m_tdata        (m_axis_tdata)
    );

endmodule

// File: hdl/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/nps_sqrt.sv
// ----------------------------------------------------------------------------
// nps_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nps_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nps_pkg::LIM2_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [nps_pkg::DIST_W-1:0]  o_root
);

    localparam int RW    = nps_pkg::DIST_W;
    localparam int REM_W = RW + 2;
    localparam int CW    = $clog2(RW);

    logic                        r_busy;
    logic [CW-1:0]               r_cnt;
    logic [nps_pkg::LIM2_W-1:0]  r_rad;
    logic [REM_W-1:0]            r_rem;
    logic [RW-1:0]               r_root;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;
    logic                        take;
    logic                        last;

    assign rem_sh = {r_rem[RW-1:0], r_rad[nps_pkg::LIM2_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);
    assign last   = (r_cnt == CW'(RW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[nps_pkg::LIM2_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && last;
    assign o_root = r_root;

endmodule

// File: hdl/nps_regs.sv
// ----------------------------------------------------------------------------
// nps_regs
// APB configuration registers: point count and distance limit.
// ----------------------------------------------------------------------------
module nps_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [nps_pkg::CNT_CFG_W-1:0]     o_point_count,
    output logic [nps_pkg::LIMIT_W-1:0]       o_distance_limit
);

    logic [nps_pkg::CNT_CFG_W-1:0] r_point_count;
    logic [nps_pkg::LIMIT_W-1:0]   r_distance_limit;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count    <= '0;
            r_distance_limit <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                nps_pkg::REG_POINT_COUNT: begin
                    r_point_count <= pwdata[nps_pkg::CNT_CFG_W-1:0];
                end
                nps_pkg::REG_DISTANCE_LIMIT: begin
                    r_distance_limit <= pwdata[nps_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            nps_pkg::REG_POINT_COUNT:    prdata = nps_pkg::APB_DATA_W'(r_point_count);
            nps_pkg::REG_DISTANCE_LIMIT: prdata = nps_pkg::APB_DATA_W'(r_distance_limit);
            default:                     prdata = '0;
        endcase
    end

    assign o_point_count    = r_point_count;
    assign o_distance_limit = r_distance_limit;

endmodule

// File: hdl/nps_dpath.sv
// ----------------------------------------------------------------------------
// nps_dpath
// Datapath: point table, distance pipeline, minimum tracking, root and output.
// ----------------------------------------------------------------------------
module nps_dpath #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nps_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_rd_addr,
    input  logic [nps_pkg::IDX_OUT_W-1:0]       i_entry_index,
    input  logic signed [COORD_BITS-1:0]        i_coord_x,
    input  logic signed [COORD_BITS-1:0]        i_coord_y,
    input  logic signed [COORD_BITS-1:0]        i_coord_z,
    input  logic [nps_pkg::LIMIT_W-1:0]         i_distance_limit,
    input  logic                                i_m_tready,
    output nps_pkg::t_status                    o_status,
    output logic                                o_m_tvalid,
    output logic [nps_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int C     = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int PT_W  = 3 * C;
    localparam int D2_W  = 2 * C + 2;
    localparam int CMP_W = (D2_W > nps_pkg::LIM2_W) ? D2_W : nps_pkg::LIM2_W;

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [PT_W-1:0]              rd_data;

    logic signed [C-1:0]          r_qx, r_qy, r_qz;
    logic [nps_pkg::LIM2_W-1:0]   r_lim2;

    logic                         r_v0, r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]             r_idx0, r_idx1, r_idx2, r_idx3;
    logic [C:0]                   r_ax, r_ay, r_az;
    logic [D2_W-1:0]              r_sx, r_sy, r_sz;
    logic [D2_W-1:0]              r_d2;

    logic                         r_have;
    logic [D2_W-1:0]              r_best;
    logic [IDX_W-1:0]             r_best_idx;

    logic signed [C:0]            dx, dy, dz;
    logic                         found;
    logic                         better;
    logic [nps_pkg::DIST_W-1:0]   root;
    logic                         sqrt_done;
    logic [CMP_W-1:0]             best_ext;

    logic                         r_out_valid;
    logic [nps_pkg::OUT_TDATA_W-1:0] r_out_data;

    assign wr_en   = i_cmd.wr && ({22'd0, i_entry_index} < 32'(MAX_POINTS));
    assign wr_addr = IDX_W'(i_entry_index);

    nps_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_coord_z, i_coord_y, i_coord_x}),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign dx = $signed({rd_data[C-1], rd_data[C-1:0]}) - $signed({r_qx[C-1], r_qx});
    assign dy = $signed({rd_data[2*C-1], rd_data[2*C-1:C]}) - $signed({r_qy[C-1], r_qy});
    assign dz = $signed({rd_data[3*C-1], rd_data[3*C-1:2*C]}) - $signed({r_qz[C-1], r_qz});

    assign better = r_v3 && (!r_have || (r_d2 < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (better) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx   <= i_coord_x;
            r_qy   <= i_coord_y;
            r_qz   <= i_coord_z;
            r_lim2 <= i_distance_limit * i_distance_limit;
        end
        r_idx0 <= i_rd_addr;
        r_idx1 <= r_idx0;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_ax   <= dx[C] ? (C + 1)'(-dx) : (C + 1)'(dx);
        r_ay   <= dy[C] ? (C + 1)'(-dy) : (C + 1)'(dy);
        r_az   <= dz[C] ? (C + 1)'(-dz) : (C + 1)'(dz);
        r_sx   <= r_ax * r_ax;
        r_sy   <= r_ay * r_ay;
        r_sz   <= r_az * r_az;
        r_d2   <= r_sx + r_sy + r_sz;
        if (better) begin
            r_best     <= r_d2;
            r_best_idx <= r_idx3;
        end
    end

    assign best_ext = CMP_W'(r_best);
    assign found    = r_have && (best_ext < CMP_W'(r_lim2));

    nps_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (best_ext[nps_pkg::LIM2_W-1:0]),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (found) begin
                r_out_data <= nps_pkg::OUT_TDATA_W'({root,
                    nps_pkg::IDX_OUT_W'(r_best_idx), 1'b1});
            end else begin
                r_out_data <= nps_pkg::OUT_TDATA_W'({{nps_pkg::DIST_W{1'b1}},
                    {nps_pkg::IDX_OUT_W{1'b0}}, 1'b0});
            end
        end
    end

    assign o_status.busy      = r_v0 || r_v1 || r_v2 || r_v3;
    assign o_status.found     = found;
    assign o_status.sqrt_done = sqrt_done;
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: hdl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: accepts requests, sequences the table scan, root and result.
// ----------------------------------------------------------------------------
module nps_ctrl #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_opcode,
    input  logic [nps_pkg::CNT_CFG_W-1:0]     i_point_count,
    input  nps_pkg::t_status                  i_status,
    output nps_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]     o_rd_addr,
    output logic                              o_s_tready
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NW    = (CNT_W > nps_pkg::CNT_CFG_W) ? CNT_W : nps_pkg::CNT_CFG_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_SQRT  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0]  count_ext;
    logic [NW-1:0]  n_eff;

    assign count_ext = NW'(i_point_count);
    assign n_eff     = (count_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : count_ext;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_opcode == nps_pkg::OP_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_cnt       = '0;
                        n_state     = ST_SCAN;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (NW'(r_cnt) < n_eff) begin
                    o_cmd.rd = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    if (i_status.found) begin
                        o_cmd.sqrt_start = 1'b1;
                        n_state          = ST_SQRT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SQRT: begin
                if (i_status.sqrt_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_rd_addr = r_cnt[IDX_W-1:0];

endmodule

// File: tb/sv/nearest_point_search_core_tb.sv
// ----------------------------------------------------------------------------
// nearest_point_search_core_tb
// Self-checking testbench for the nearest point search core. Table writes and
// queries go in on the request stream, and the two registers are set over APB
// while the core is idle. A scoreboard keeps its own copy of the point table
// and predicts the index and rounded-down distance of the nearest stored
// point for every query. Each returned result is checked against the oldest
// prediction. Directed requests come first, then phases of random requests
// with several register settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module nearest_point_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPOINTS     = nps_pkg::MAX_POINTS_DEF;
    localparam int COORD_W     = nps_pkg::COORD_BITS_DEF;
    localparam int IN_TDATA_W  = ((10 + 3 * COORD_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 14;
    localparam int PHASE_REQS  = 38;

    localparam logic [nps_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef longint unsigned t_u64;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    typedef struct packed {
        logic [nps_pkg::DIST_W-1:0]    distance;
        logic [nps_pkg::IDX_OUT_W-1:0] slot;
        logic                          found;
    } t_match;

    class nearest_scoreboard;
        t_coord                        point_x [NPOINTS];
        t_coord                        point_y [NPOINTS];
        t_coord                        point_z [NPOINTS];
        logic [nps_pkg::CNT_CFG_W-1:0] point_count;
        logic [nps_pkg::LIMIT_W-1:0]   distance_limit;
        t_match                        expected_matches [$];
        int                            mismatches;

        function new();
            point_count    = '0;
            distance_limit = '0;
            mismatches     = 0;
        endfunction

        function void set_register(logic sel, logic [nps_pkg::APB_DATA_W-1:0] value);
            if (sel == nps_pkg::REG_POINT_COUNT) begin
                point_count = value[nps_pkg::CNT_CFG_W-1:0];
            end else begin
                distance_limit = value[nps_pkg::LIMIT_W-1:0];
            end
        endfunction

        function t_u64 floor_root(t_u64 v);
            t_u64 root;
            t_u64 trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (t_u64'(1) << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function t_match nearest_match(t_coord qx, t_coord qy, t_coord qz);
            int unsigned scanned;
            longint      dx, dy, dz;
            t_u64        sq, best, lim2, root;
            int          best_slot;
            bit          have;
            t_match      m;
            scanned   = (point_count > NPOINTS) ? NPOINTS : point_count;
            have      = 1'b0;
            best      = 0;
            best_slot = 0;
            for (int i = 0; i < scanned; i++) begin
                dx = longint'(point_x[i]) - longint'(qx);
                dy = longint'(point_y[i]) - longint'(qy);
                dz = longint'(point_z[i]) - longint'(qz);
                sq = t_u64'(dx * dx + dy * dy + dz * dz);
                if (!have || sq < best) begin
                    best      = sq;
                    best_slot = i;
                    have      = 1'b1;
                end
            end
            lim2 = t_u64'(distance_limit) * t_u64'(distance_limit);
            if (have && best < lim2) begin
                root       = floor_root(best);
                m.found    = 1'b1;
                m.slot     = best_slot[nps_pkg::IDX_OUT_W-1:0];
                m.distance = root[nps_pkg::DIST_W-1:0];
            end else begin
                m.found    = 1'b0;
                m.slot     = '0;
                m.distance = '1;
            end
            return m;
        endfunction

        function void note_request(logic op, logic [9:0] slot, t_coord x, t_coord y,
                                   t_coord z);
            if (op == nps_pkg::OP_WRITE) begin
                point_x[slot] = x;
                point_y[slot] = y;
                point_z[slot] = z;
            end else begin
                expected_matches.push_back(nearest_match(x, y, z));
            end
        endfunction

        function void check_match(logic [nps_pkg::OUT_TDATA_W-1:0] data);
            t_match got;
            t_match want;
            got = t_match'(data[nps_pkg::OUT_FIELDS_W-1:0]);
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: found=%0d index=%0d distance=%0d",
                             got.found, got.slot, got.distance);
                end
            end else begin
                want = expected_matches.pop_front();
                if (got.found !== want.found || got.slot !== want.slot ||
                    got.distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected found=%0d index=%0d distance=%0d",
                                 want.found, want.slot, want.distance);
                        $display("          actual   found=%0d index=%0d distance=%0d",
                                 got.found, got.slot, got.distance);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction
    endclass

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    // entry_index, coord_x, coord_y, coord_z
    logic [IN_TDATA_W-1:0]             s_axis_tdata  = '0;
    // opcode
    logic                              s_axis_tuser  = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // found, nearest_index, distance
    logic [nps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [nps_pkg::APB_ADDR_W-1:0]    paddr         = '0;
    logic [nps_pkg::APB_DATA_W-1:0]    pwdata        = '0;
    logic [nps_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    int                      src_idle_pct   = 0;
    int                      sink_stall_pct = 0;
    int unsigned             cycle_count    = 0;
    bit                      written [NPOINTS];
    nearest_scoreboard       board;

    nearest_point_search_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count   <= cycle_count + 1;
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_match(m_axis_tdata);
        end
    end

    function automatic t_coord rand_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    function automatic t_coord nudge(t_coord base, int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return t_coord'(int'(base) + off);
    endfunction

    function automatic int unsigned written_prefix();
        int unsigned n;
        n = 0;
        while (n < NPOINTS && written[n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic set_idle(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
            default: begin src_idle_pct = 35; sink_stall_pct = 35; end
        endcase
    endtask

    task automatic send_request(logic op, logic [9:0] slot, t_coord x, t_coord y,
                                t_coord z);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({z, y, x, slot});
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        board.note_request(op, slot, x, y, z);
    endtask

    task automatic store_point(int unsigned slot, t_coord x, t_coord y, t_coord z);
        written[slot] = 1'b1;
        send_request(nps_pkg::OP_WRITE, slot[9:0], x, y, z);
    endtask

    task automatic configure(int unsigned count, int unsigned limit);
        logic [nps_pkg::APB_DATA_W-1:0] value;
        logic                           sel;
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        for (int k = 0; k < 2; k++) begin
            sel   = (k == 0) ? nps_pkg::REG_POINT_COUNT : nps_pkg::REG_DISTANCE_LIMIT;
            value = (k == 0) ? count : limit;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= nps_pkg::APB_ADDR_W'({sel, 2'b00});
            pwdata  <= value;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) begin
                @(posedge i_clk);
            end
            board.set_register(sel, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_write();
        int unsigned pre, slot, src, r, span;
        t_coord      x, y, z;
        pre  = written_prefix();
        r    = $urandom_range(0, 99);
        if (r < 25 && pre < NPOINTS) begin
            slot = pre;
        end else if (r < 60) begin
            slot = $urandom_range(0, (pre < NPOINTS) ? pre : NPOINTS - 1);
        end else begin
            slot = $urandom_range(0, NPOINTS - 1);
        end
        src  = $urandom_range(0, (pre > 0) ? pre - 1 : 0);
        span = 1 << $urandom_range(0, 14);
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            x = board.point_x[src];
            y = board.point_y[src];
            z = board.point_z[src];
        end else if (r < 40) begin
            x = nudge(board.point_x[src], span);
            y = nudge(board.point_y[src], span);
            z = nudge(board.point_z[src], span);
        end else if (r < 60) begin
            x = nudge('0, span);
            y = nudge('0, span);
            z = nudge('0, span);
        end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
        end
        store_point(slot, x, y, z);
    endtask

    task automatic random_query();
        int unsigned scanned, src, r, span;
        logic [31:0] junk;
        t_coord      x, y, z;
        scanned = (board.point_count > NPOINTS) ? NPOINTS : board.point_count;
        src     = (scanned > 0) ? $urandom_range(0, scanned - 1) : 0;
        span    = 1 << $urandom_range(0, 14);
        junk    = $urandom();
        r       = $urandom_range(0, 99);
        if (scanned > 0 && r < 15) begin
            x = board.point_x[src];
            y = board.point_y[src];
            z = board.point_z[src];
        end else if (scanned > 0 && r < 60) begin
            x = nudge(board.point_x[src], span);
            y = nudge(board.point_y[src], span);
            z = nudge(board.point_z[src], span);
        end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
        end
        send_request(nps_pkg::OP_QUERY, junk[9:0], x, y, z);
    endtask

    initial begin
        bit          timed_out;
        int unsigned pre, count, limit, r;
        board     = new();
        timed_out = 1'b0;
        fork
            begin
                repeat (12) @(posedge i_clk);
                i_rst_n <= 1'b1;
                set_idle(0);

                // Empty table straight after reset.
                send_request(nps_pkg::OP_QUERY, 10'd0, 0, 0, 0);
                send_request(nps_pkg::OP_QUERY, 10'h3FF, COORD_MAX, COORD_MIN, COORD_MAX);
                store_point(0, COORD_MAX, COORD_MAX, COORD_MAX);
                store_point(1, COORD_MIN, COORD_MIN, COORD_MIN);
                store_point(2, 0, 0, 0);
                store_point(3, 0, 0, 0);
                store_point(4, -1, 1, 256);
                store_point(NPOINTS - 1, COORD_MIN, COORD_MAX, -1);
                configure(5, LIMIT_MAX);
                send_request(nps_pkg::OP_QUERY, 10'd7, 0, 0, 0);
                send_request(nps_pkg::OP_QUERY, 10'd0, COORD_MAX, COORD_MAX, COORD_MAX);
                send_request(nps_pkg::OP_QUERY, 10'd0, COORD_MIN, COORD_MIN, COORD_MIN);
                send_request(nps_pkg::OP_QUERY, 10'd0, COORD_MAX, COORD_MIN, 0);
                send_request(nps_pkg::OP_QUERY, 10'd0, -1, 1, 255);
                send_request(nps_pkg::OP_QUERY, 10'd0, 1, 1, 1);
                configure(5, 0);
                send_request(nps_pkg::OP_QUERY, 10'd0, 0, 0, 0);
                configure(5, 1);
                send_request(nps_pkg::OP_QUERY, 10'd0, 0, 0, 0);
                send_request(nps_pkg::OP_QUERY, 10'd0, 0, 0, 1);
                send_request(nps_pkg::OP_QUERY, 10'd0, COORD_MAX, COORD_MIN, 0);

                for (int p = 0; p < PHASES; p++) begin
                    pre = written_prefix();
                    r   = $urandom_range(0, 9);
                    if (r == 0) begin
                        count = 0;
                    end else if (r < 3) begin
                        count = (pre > 256) ? 256 : pre;
                    end else begin
                        count = $urandom_range(1, (pre > 40) ? 40 : pre);
                    end
                    case ($urandom_range(0, 5))
                        0: limit = 0;
                        1: limit = 1;
                        2: limit = LIMIT_MAX;
                        3: limit = $urandom_range(2, 4096);
                        4: limit = $urandom_range(4096, 1 << 20);
                        default: limit = $urandom() & LIMIT_MAX;
                    endcase
                    configure(count, limit);
                    set_idle(p % 4);
                    for (int k = 0; k < PHASE_REQS; k++) begin
                        if ($urandom_range(0, 99) < 35) begin
                            random_write();
                        end else begin
                            random_query();
                        end
                    end
                end

                s_axis_tvalid <= 1'b0;
                while (board.pending() != 0) begin
                    @(posedge i_clk);
                end
                repeat (50) @(posedge i_clk);
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out) begin
            $display("Test completed with failures");
        end else if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/nps_pkg.sv
hdl/nps_ram.sv
hdl/nps_sqrt.sv
hdl/nps_regs.sv
hdl/nps_dpath.sv
hdl/nps_ctrl.sv
hdl/nearest_point_search_core.sv
tb/sv/nearest_point_search_core_tb.sv
